// ===== hdl/dpalu_pkg.sv =====
// shared types and constants for the data-processing alu
`default_nettype none

package dpalu_pkg;

   localparam int unsigned DATA_W = 32;

   localparam logic [3:0] PC_INDEX = 4'd15;

   // flag bit positions in an nzcv nibble
   localparam int unsigned FLAG_N = 3;
   localparam int unsigned FLAG_Z = 2;
   localparam int unsigned FLAG_C = 1;
   localparam int unsigned FLAG_V = 0;

   typedef enum logic [3:0] {
      OP_AND = 4'd0,
      OP_EOR = 4'd1,
      OP_SUB = 4'd2,
      OP_RSB = 4'd3,
      OP_ADD = 4'd4,
      OP_ADC = 4'd5,
      OP_SBC = 4'd6,
      OP_RSC = 4'd7,
      OP_TST = 4'd8,
      OP_TEQ = 4'd9,
      OP_CMP = 4'd10,
      OP_CMN = 4'd11,
      OP_ORR = 4'd12,
      OP_MOV = 4'd13,
      OP_BIC = 4'd14,
      OP_MVN = 4'd15
   } op_type;

   typedef struct packed {
      logic       arith;
      logic       wr;
      logic       upd;
      logic       shc;
      logic [3:0] rd;
      logic [3:0] flags;
   } ctrl_type;

   typedef struct packed {
      logic c;
      logic v;
   } add_flags_type;

endpackage

`default_nettype wire

// ===== hdl/dpalu_flags.sv =====
// nzcv flag generation from a finished result
`default_nettype none

module dpalu_flags (
   input  wire dpalu_pkg::ctrl_type      ctrl,
   input  wire dpalu_pkg::add_flags_type add_flags,
   input  wire logic [31:0]              result,
   output logic [3:0]                    flags_out
);
   import dpalu_pkg::*;

   logic [3:0] nf;

   always_comb begin
      nf         = '0;
      nf[FLAG_N] = result[DATA_W-1];
      nf[FLAG_Z] = (result == '0);
      if (ctrl.arith) begin
         nf[FLAG_C] = add_flags.c;
         nf[FLAG_V] = add_flags.v;
      end else begin
         nf[FLAG_C] = ctrl.shc;
         nf[FLAG_V] = ctrl.flags[FLAG_V];
      end
      flags_out = ctrl.upd ? nf : ctrl.flags;
   end

endmodule

`default_nettype wire

// ===== hdl/arm_data_processing_alu.sv =====
// three-stage armv4t data-processing alu with valid/stall handshake
// an accepted req beat crosses the stage 1, 2 and 3 registers to rsp_valid; a stall holds it
// throughput: one beat per cycle unless stalled; stages: operand prep, 32-bit add, flags
// each stage loads when it is empty or its content moves on, so bubbles are squeezed
// reset: synchronous, active high; clears the stage valid bits only
`default_nettype none

module arm_data_processing_alu (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_opcode,
   input  wire logic [31:0] req_first_operand,
   input  wire logic [31:0] req_second_operand,
   input  wire logic        req_shifter_carry,
   input  wire logic        req_set_flags,
   input  wire logic [3:0]  req_dest_index,
   input  wire logic [3:0]  req_flags_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_result,
   output logic             rsp_write_enable,
   output logic [3:0]       rsp_write_index,
   output logic [3:0]       rsp_flags_out
);
   import dpalu_pkg::*;

   logic adv1, adv2, adv3;

   // stage 1: operand prep
   logic              v1_ff;
   logic [31:0]       add_a_ff, add_a_in;
   logic [31:0]       add_b_ff, add_b_in;
   logic              cin_ff, cin_in;
   logic [31:0]       logic_ff, logic_in;
   ctrl_type          ctrl1_ff, ctrl1_in;

   // stage 2: add and result select
   logic              v2_ff;
   logic [31:0]       res2_ff, res2_in;
   add_flags_type     af2_ff, af2_in;
   ctrl_type          ctrl2_ff;

   // stage 3: output register
   logic              v3_ff;
   logic [31:0]       res3_ff;
   logic              wr3_ff;
   logic [3:0]        rd3_ff;
   logic [3:0]        flags3_ff, flags3_in;

   logic [32:0]       sum;
   op_type            op;

   assign adv3 = !v3_ff || !rsp_stall;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_stall = !adv1;

   always_comb begin
      op             = op_type'(req_opcode);
      add_a_in       = req_first_operand;
      add_b_in       = req_second_operand;
      cin_in         = 1'b0;
      logic_in       = req_first_operand & req_second_operand;
      ctrl1_in.arith = 1'b0;
      ctrl1_in.wr    = 1'b1;
      unique case (op)
         OP_AND: logic_in = req_first_operand & req_second_operand;
         OP_EOR: logic_in = req_first_operand ^ req_second_operand;
         OP_SUB: begin
            add_b_in = ~req_second_operand;
            cin_in   = 1'b1;
            ctrl1_in.arith = 1'b1;
         end
         OP_RSB: begin
            add_a_in = req_second_operand;
            add_b_in = ~req_first_operand;
            cin_in   = 1'b1;
            ctrl1_in.arith = 1'b1;
         end
         OP_ADD: ctrl1_in.arith = 1'b1;
         OP_ADC: begin
            cin_in   = req_flags_in[FLAG_C];
            ctrl1_in.arith = 1'b1;
         end
         OP_SBC: begin
            add_b_in = ~req_second_operand;
            cin_in   = req_flags_in[FLAG_C];
            ctrl1_in.arith = 1'b1;
         end
         OP_RSC: begin
            add_a_in = req_second_operand;
            add_b_in = ~req_first_operand;
            cin_in   = req_flags_in[FLAG_C];
            ctrl1_in.arith = 1'b1;
         end
         OP_TST: begin
            logic_in    = req_first_operand & req_second_operand;
            ctrl1_in.wr = 1'b0;
         end
         OP_TEQ: begin
            logic_in    = req_first_operand ^ req_second_operand;
            ctrl1_in.wr = 1'b0;
         end
         OP_CMP: begin
            add_b_in = ~req_second_operand;
            cin_in   = 1'b1;
            ctrl1_in.arith = 1'b1;
            ctrl1_in.wr    = 1'b0;
         end
         OP_CMN: begin
            ctrl1_in.arith = 1'b1;
            ctrl1_in.wr    = 1'b0;
         end
         OP_ORR: logic_in = req_first_operand | req_second_operand;
         OP_MOV: logic_in = req_second_operand;
         OP_BIC: logic_in = req_first_operand & ~req_second_operand;
         OP_MVN: logic_in = ~req_second_operand;
         default: logic_in = ~req_second_operand;
      endcase
      // a flag-setting write to the pc leaves the flags alone
      ctrl1_in.upd   = req_set_flags && !(req_dest_index == PC_INDEX && ctrl1_in.wr);
      ctrl1_in.shc   = req_shifter_carry;
      ctrl1_in.rd    = req_dest_index;
      ctrl1_in.flags = req_flags_in;
   end

   always_comb begin
      sum      = {1'b0, add_a_ff} + {1'b0, add_b_ff} + {32'd0, cin_ff};
      af2_in.c = sum[DATA_W];
      af2_in.v = ~(add_a_ff[DATA_W-1] ^ add_b_ff[DATA_W-1])
                 & (add_a_ff[DATA_W-1] ^ sum[DATA_W-1]);
      res2_in  = ctrl1_ff.arith ? sum[DATA_W-1:0] : logic_ff;
   end

   dpalu_flags u_flags (
      .ctrl      (ctrl2_ff),
      .add_flags (af2_ff),
      .result    (res2_ff),
      .flags_out (flags3_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         add_a_ff <= add_a_in;
         add_b_ff <= add_b_in;
         cin_ff   <= cin_in;
         logic_ff <= logic_in;
         ctrl1_ff <= ctrl1_in;
      end
      if (adv2) begin
         res2_ff  <= res2_in;
         af2_ff   <= af2_in;
         ctrl2_ff <= ctrl1_ff;
      end
      if (adv3) begin
         res3_ff   <= res2_ff;
         wr3_ff    <= ctrl2_ff.wr;
         rd3_ff    <= ctrl2_ff.rd;
         flags3_ff <= flags3_in;
      end
   end

   assign rsp_valid        = v3_ff;
   assign rsp_result       = res3_ff;
   assign rsp_write_enable = wr3_ff;
   assign rsp_write_index  = rd3_ff;
   assign rsp_flags_out    = flags3_ff;

   // a free output means the whole pipe moves
   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("req stalled while rsp side is free");

   // an accepted beat reaches the output when rsp_stall stays low behind it
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 (!rsp_stall)[*2] |=> rsp_valid)
      else $error("accepted beat did not reach the output in time");

   // input is only held back when every stage is full
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff))
      else $error("req stalled with a free stage");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

`default_nettype wire
